>>> hw/rtl/crs_pkg.sv
package crs_pkg;

    // Field and register widths
    localparam int TOTAL_W   = 11;
    localparam int TIMEOUT_W = 16;
    localparam int IDX_W     = 10;
    localparam int TIME_W    = 32;
    localparam int REQ_W     = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int LIMIT_W   = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_NEXT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SENT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ACK  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NAME = 2'd3;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd10;

    // In-flight limit: total/10, at least one chunk for small blobs.
    // total/10 == (total * 1639) >> 14 for every 11-bit total.
    localparam logic [TOTAL_W-1:0] LIMIT_DIV    = 11'd10;
    localparam logic [TOTAL_W-1:0] DIV10_MUL    = 11'd1639;
    localparam int                 DIV10_SHIFT  = 14;

    // Controller -> datapath
    typedef struct packed {
        logic load;          // latch a new request
        logic issue_unsent;  // offer unsent pointer, advance it
        logic issue_resend;  // advance resend pointer, offer it
        logic scan_start;    // begin first-clear scan
        logic scan_map;      // 0: sent map, 1: ack map
        logic scan_step;     // scan one entry
        logic scan_take;     // scan result is ready, use it
        logic set_bit;       // sent/ack report update
        logic set_name;      // name acknowledged update
        logic set_err;       // index out of range
        logic finish;        // capture completion flag
        logic clr_step;      // clear one bitmap entry
    } crs_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic in_range;
        logic ack_full;
        logic in_limit;      // chunks in flight within the limit
        logic unsent_end;
        logic elapsed;
        logic rs_wrap;
        logic scan_done;
        logic clr_last;
        logic restart;
    } crs_stat_t;

endpackage

>>> hw/rtl/crs_datapath.sv
module crs_datapath #(
    parameter int MAX_CHUNKS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [crs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [crs_pkg::CFG_W-1:0]       cfg_data,
    input  logic [crs_pkg::REQ_W-1:0]       req_type,
    input  logic [crs_pkg::IDX_W-1:0]       chunk_index,
    input  logic                            name_flag,
    input  logic [crs_pkg::TIME_W-1:0]      now_ms,
    input  crs_pkg::crs_cmd_t               cmd,
    output crs_pkg::crs_stat_t              stat,
    output logic                            chunk_valid,
    output logic [crs_pkg::IDX_W-1:0]       chunk_out,
    output logic                            is_resend,
    output logic                            done_res,
    output logic                            status
);
    import crs_pkg::*;

    // Effective total is capped by the parameter and by the register width
    localparam int TOTAL_MAX = (1 << TOTAL_W) - 1;
    localparam int CAP       = (MAX_CHUNKS > TOTAL_MAX) ? TOTAL_MAX : MAX_CHUNKS;
    // Only indexes below 2^IDX_W can ever be marked
    localparam int MD        = (MAX_CHUNKS < (1 << IDX_W)) ? MAX_CHUNKS : (1 << IDX_W);
    localparam int AW        = (MD > 1) ? $clog2(MD) : 1;

    logic [TOTAL_W-1:0]   total_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [LIMIT_W-1:0]   limit_reg;

    logic [REQ_W-1:0]     req_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 flag_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [TIME_W-1:0]    nowto_reg;

    logic [TOTAL_W-1:0]   sent_cnt_reg;
    logic [TOTAL_W-1:0]   ack_cnt_reg;
    logic [TOTAL_W-1:0]   unsent_ptr_reg;
    logic [TOTAL_W-1:0]   resend_ptr_reg;
    logic [TIME_W-1:0]    last_send_reg;
    logic                 name_reg;

    logic [AW-1:0]        clr_idx_reg;
    logic [TOTAL_W-1:0]   scan_idx_reg;
    logic [TOTAL_W-1:0]   chk_idx_reg;
    logic                 chk_vld_reg;
    logic                 scan_map_reg;

    logic                 valid_reg;
    logic [IDX_W-1:0]     chunk_reg;
    logic                 resend_reg;
    logic                 status_reg;
    logic                 done_reg;

    logic                 sent_mem [MD];
    logic                 ack_mem  [MD];
    logic                 rd_sent_reg;
    logic                 rd_ack_reg;

    logic [TOTAL_W-1:0]   eff_t;
    logic [2*TOTAL_W-1:0] t_mul;
    logic [LIMIT_W-1:0]   limit_next;
    logic [TOTAL_W:0]     inflight;
    logic [TIME_W-1:0]    since;
    logic [TOTAL_W-1:0]   rs_next;
    logic [TOTAL_W-1:0]   rd_addr;
    logic                 rd_ok;
    logic                 scan_bit;
    logic                 restart;
    logic                 wr_clr;
    logic                 wr_sent;
    logic                 wr_ack;
    logic [AW-1:0]        wr_addr;
    logic                 cur_bit;

    assign eff_t   = (total_reg > TOTAL_W'(CAP)) ? TOTAL_W'(CAP) : total_reg;
    assign t_mul   = {{TOTAL_W{1'b0}}, eff_t} * {{TOTAL_W{1'b0}}, DIV10_MUL};
    assign restart = cfg_we && (cfg_index == CFG_TOTAL);

    always_comb
    begin
        if (eff_t == '0)
        begin
            limit_next = '0;
        end
        else if (eff_t <= LIMIT_DIV)
        begin
            limit_next = LIMIT_W'(1);
        end
        else
        begin
            limit_next = LIMIT_W'(t_mul >> DIV10_SHIFT);
        end
    end

    assign inflight = {1'b0, sent_cnt_reg} - {1'b0, ack_cnt_reg};
    assign since    = nowto_reg - last_send_reg;
    assign rs_next  = resend_ptr_reg + TOTAL_W'(1);
    assign rd_addr  = cmd.scan_step ? scan_idx_reg : {1'b0, idx_reg};
    assign rd_ok    = rd_addr < TOTAL_W'(MD);
    assign scan_bit = scan_map_reg ? rd_ack_reg : rd_sent_reg;
    assign cur_bit  = (req_reg == REQ_SENT) ? rd_sent_reg : rd_ack_reg;

    assign stat.req        = req_reg;
    assign stat.in_range   = {1'b0, idx_reg} < eff_t;
    assign stat.ack_full   = ack_cnt_reg >= eff_t;
    assign stat.in_limit   = $signed(inflight) <= $signed({{(TOTAL_W+1-LIMIT_W){1'b0}}, limit_reg});
    assign stat.unsent_end = unsent_ptr_reg >= eff_t;
    assign stat.elapsed    = (since != '0) && !since[TIME_W-1];
    assign stat.rs_wrap    = rs_next >= eff_t;
    assign stat.scan_done  = chk_vld_reg && (!scan_bit || (scan_idx_reg == eff_t));
    assign stat.clr_last   = clr_idx_reg == AW'(MD - 1);
    assign stat.restart    = restart;

    // Bitmap write port: clearing pass or report update
    assign wr_clr  = cmd.clr_step;
    assign wr_sent = wr_clr || (cmd.set_bit && (req_reg == REQ_SENT));
    assign wr_ack  = wr_clr || (cmd.set_bit && (req_reg == REQ_ACK));
    assign wr_addr = wr_clr ? clr_idx_reg : idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_sent)
        begin
            sent_mem[wr_addr] <= !wr_clr;
        end
        if (wr_ack)
        begin
            ack_mem[wr_addr] <= !wr_clr;
        end
        rd_sent_reg <= rd_ok ? sent_mem[rd_addr[AW-1:0]] : 1'b0;
        rd_ack_reg  <= rd_ok ? ack_mem[rd_addr[AW-1:0]]  : 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg      <= '0;
            timeout_reg    <= TIMEOUT_RESET;
            limit_reg      <= '0;
            req_reg        <= REQ_NEXT;
            idx_reg        <= '0;
            flag_reg       <= 1'b0;
            now_reg        <= '0;
            nowto_reg      <= '0;
            sent_cnt_reg   <= '0;
            ack_cnt_reg    <= '0;
            unsent_ptr_reg <= '0;
            resend_ptr_reg <= '0;
            last_send_reg  <= '0;
            name_reg       <= 1'b0;
            clr_idx_reg    <= '0;
            scan_idx_reg   <= '0;
            chk_idx_reg    <= '0;
            chk_vld_reg    <= 1'b0;
            scan_map_reg   <= 1'b0;
            valid_reg      <= 1'b0;
            chunk_reg      <= '0;
            resend_reg     <= 1'b0;
            status_reg     <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            limit_reg <= limit_next;

            if (cfg_we && (cfg_index == CFG_TIMEOUT))
            begin
                timeout_reg <= cfg_data[TIMEOUT_W-1:0];
            end

            if (cmd.load)
            begin
                req_reg    <= req_type;
                idx_reg    <= chunk_index;
                flag_reg   <= name_flag;
                now_reg    <= now_ms;
                nowto_reg  <= now_ms - {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_reg};
                valid_reg  <= 1'b0;
                chunk_reg  <= '0;
                resend_reg <= 1'b0;
                status_reg <= 1'b0;
            end

            if (cmd.issue_unsent)
            begin
                valid_reg      <= 1'b1;
                chunk_reg      <= unsent_ptr_reg[IDX_W-1:0];
                unsent_ptr_reg <= unsent_ptr_reg + TOTAL_W'(1);
            end

            if (cmd.issue_resend)
            begin
                valid_reg      <= 1'b1;
                resend_reg     <= 1'b1;
                chunk_reg      <= rs_next[IDX_W-1:0];
                resend_ptr_reg <= rs_next;
            end

            if (cmd.scan_start)
            begin
                scan_idx_reg <= '0;
                chk_vld_reg  <= 1'b0;
                scan_map_reg <= cmd.scan_map;
            end

            // One read issued per cycle; its bit is checked the next cycle
            if (cmd.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + TOTAL_W'(1);
                chk_idx_reg  <= scan_idx_reg;
                chk_vld_reg  <= 1'b1;
            end

            // chk_idx is the first clear bit, or total-1 at the end
            if (cmd.scan_take)
            begin
                valid_reg   <= 1'b1;
                chunk_reg   <= chk_idx_reg[IDX_W-1:0];
                chk_vld_reg <= 1'b0;
                if (scan_map_reg)
                begin
                    resend_reg     <= 1'b1;
                    resend_ptr_reg <= chk_idx_reg;
                end
                else
                begin
                    unsent_ptr_reg <= chk_idx_reg + TOTAL_W'(1);
                end
            end

            if (cmd.set_bit)
            begin
                if (req_reg == REQ_SENT)
                begin
                    last_send_reg <= now_reg;
                    if (!cur_bit)
                    begin
                        sent_cnt_reg <= sent_cnt_reg + TOTAL_W'(1);
                    end
                end
                else if (!cur_bit)
                begin
                    ack_cnt_reg <= ack_cnt_reg + TOTAL_W'(1);
                end
            end

            if (cmd.set_name)
            begin
                name_reg <= flag_reg;
            end

            if (cmd.set_err)
            begin
                status_reg <= 1'b1;
            end

            if (cmd.finish)
            begin
                done_reg <= (ack_cnt_reg >= eff_t) && name_reg;
            end

            if (cmd.clr_step)
            begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
            end

            // New blob: drop all tracking state, sweep restarts from entry 0
            if (restart)
            begin
                total_reg      <= cfg_data[TOTAL_W-1:0];
                sent_cnt_reg   <= '0;
                ack_cnt_reg    <= '0;
                unsent_ptr_reg <= '0;
                resend_ptr_reg <= '0;
                last_send_reg  <= '0;
                name_reg       <= 1'b0;
                clr_idx_reg    <= '0;
            end
        end
    end

    assign chunk_valid = valid_reg;
    assign chunk_out   = chunk_reg;
    assign is_resend   = resend_reg;
    assign done_res    = done_reg;
    assign status      = status_reg;

endmodule

>>> hw/rtl/crs_ctrl.sv
module crs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  crs_pkg::crs_stat_t  stat,
    output crs_pkg::crs_cmd_t   cmd,
    output logic                busy,
    output logic                result_valid
);
    import crs_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_UPDATE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FINISH;
                case (stat.req)
                    REQ_NEXT:
                    begin
                        if (!stat.ack_full)
                        begin
                            if (stat.in_limit)
                            begin
                                if (stat.unsent_end)
                                begin
                                    cmd.scan_start = 1'b1;
                                    state_next     = ST_SCAN;
                                end
                                else
                                begin
                                    cmd.issue_unsent = 1'b1;
                                end
                            end
                            else if (stat.elapsed)
                            begin
                                if (stat.rs_wrap)
                                begin
                                    cmd.scan_start = 1'b1;
                                    cmd.scan_map   = 1'b1;
                                    state_next     = ST_SCAN;
                                end
                                else
                                begin
                                    cmd.issue_resend = 1'b1;
                                end
                            end
                        end
                    end
                    REQ_SENT, REQ_ACK:
                    begin
                        if (stat.in_range)
                        begin
                            state_next = ST_UPDATE;
                        end
                        else
                        begin
                            cmd.set_err = 1'b1;
                        end
                    end
                    REQ_NAME:
                    begin
                        cmd.set_name = 1'b1;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_UPDATE:
            begin
                cmd.set_bit = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    cmd.scan_take = 1'b1;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (stat.restart)
        begin
            state_next = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= (state_reg == ST_FINISH);
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;

endmodule

>>> hw/rtl/chunk_retransmit_scheduler.sv
// Sender-side chunk scheduler (selective repeat). A request is taken on a
// clock edge with start high and busy low; its single result appears on the
// result ports for exactly one cycle with result_valid high, and the receiver
// cannot stall it, so it must capture the transfer in that cycle. Path per
// request: next-chunk, name and out-of-range reports pass through the EXEC
// and FINISH states; in-range sent/acknowledged reports add an UPDATE state
// (read-modify-write of the bitmap RAM). When the unsent pointer has run
// past the end, or the resend pointer wraps, a first-clear-bit scan walks the
// bitmap one entry per cycle through the RAM read port in the SCAN state.
// After reset and after every write of total_chunks the block runs a
// clearing pass over the first min(MAX_CHUNKS, 1024) entries of both
// bitmaps, during which busy is high; config writes are still taken.
module chunk_retransmit_scheduler #(
    parameter int MAX_CHUNKS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config write port
    input  logic                            cfg_we,
    input  logic [crs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [crs_pkg::CFG_W-1:0]       cfg_data,
    // request
    input  logic                            start,
    output logic                            busy,
    input  logic [crs_pkg::REQ_W-1:0]       req_type,
    input  logic [crs_pkg::IDX_W-1:0]       chunk_index,
    input  logic                            name_flag,
    input  logic [crs_pkg::TIME_W-1:0]      now_ms,
    // result
    output logic                            result_valid,
    output logic                            chunk_valid,
    output logic [crs_pkg::IDX_W-1:0]       chunk_out,
    output logic                            is_resend,
    output logic                            done_res,
    output logic                            status
);
    import crs_pkg::*;

    crs_cmd_t  cmd;
    crs_stat_t stat;

    // Sequencer: decides the path of each request from datapath status
    crs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .stat         (stat),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    // Bitmaps, counters, pointers and the result registers
    crs_datapath #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (req_type),
        .chunk_index (chunk_index),
        .name_flag   (name_flag),
        .now_ms      (now_ms),
        .cmd         (cmd),
        .stat        (stat),
        .chunk_valid (chunk_valid),
        .chunk_out   (chunk_out),
        .is_resend   (is_resend),
        .done_res    (done_res),
        .status      (status)
    );

endmodule

>>> hw/rtl/crs_checker.sv
module crs_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        result_valid,
    input  logic                        chunk_valid,
    input  logic [crs_pkg::IDX_W-1:0]   chunk_out,
    input  logic                        is_resend,
    input  logic                        status
);

    // Accepted transfer makes the block busy until its result is out
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after an accepted request");

    // Every result is a single-cycle strobe
    a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    // Nothing offered: chunk fields read as zero
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !chunk_valid) |-> (chunk_out == '0 && !is_resend))
        else $error("chunk fields set without an offered chunk");

    // Rejected report never offers a chunk
    a_err_no_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status) |-> !chunk_valid)
        else $error("chunk offered together with a range error");

endmodule

bind chunk_retransmit_scheduler crs_checker u_crs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .chunk_valid  (chunk_valid),
    .chunk_out    (chunk_out),
    .is_resend    (is_resend),
    .status       (status)
);

>>> tb/sv/chunk_retransmit_scheduler_tb.sv
module chunk_retransmit_scheduler_tb;

    import crs_pkg::*;

    localparam int MAX_CHUNKS  = 1024;
    // Longest quiet stretch of a correct run is a clearing pass plus a full
    // first-clear scan; allow several times that.
    localparam int STALL_LIMIT = 6000;
    localparam int TAIL_CYCLES = 16;

    // One request transfer and the result it causes
    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [IDX_W-1:0]  idx;
        logic              flag;
        logic [TIME_W-1:0] now;
    } req_item_t;

    typedef struct packed {
        logic             chunk_valid;
        logic [IDX_W-1:0] chunk_out;
        logic             is_resend;
        logic             done_res;
        logic             status;
    } sched_out_t;

    // Results that can be read off directly
    localparam sched_out_t OUT_IDLE   = '{1'b0, 10'd0, 1'b0, 1'b0, 1'b0};
    localparam sched_out_t OUT_REJECT = '{1'b0, 10'd0, 1'b0, 1'b0, 1'b1};
    localparam sched_out_t OUT_DONE   = '{1'b0, 10'd0, 1'b0, 1'b1, 1'b0};

    typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [CFG_IDX_W-1:0] sel;
        logic [CFG_W-1:0]  val;
        logic [REQ_W-1:0]  req;
        logic [IDX_W-1:0]  idx;
        logic              flag;
        logic [TIME_W-1:0] now;
        bit                fixed;   // 1: want is the result, 0: predictor decides
        sched_out_t        want;
    } dir_row_t;

    typedef struct {
        logic [CFG_W-1:0] total_val;
        logic [CFG_W-1:0] timeout_val;
        int               count;
        bit               bursty;
    } phase_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 start;
    logic                 busy;
    logic [REQ_W-1:0]     req_type;
    logic [IDX_W-1:0]     chunk_index;
    logic                 name_flag;
    logic [TIME_W-1:0]    now_ms;
    logic                 result_valid;
    logic                 chunk_valid;
    logic [IDX_W-1:0]     chunk_out;
    logic                 is_resend;
    logic                 done_res;
    logic                 status;

    chunk_retransmit_scheduler #(
        .MAX_CHUNKS(MAX_CHUNKS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .chunk_index (chunk_index),
        .name_flag   (name_flag),
        .now_ms      (now_ms),
        .result_valid(result_valid),
        .chunk_valid (chunk_valid),
        .chunk_out   (chunk_out),
        .is_resend   (is_resend),
        .done_res    (done_res),
        .status      (status)
    );

    // Directed opening. Starts at the reset setting (no chunks, timeout 10),
    // then a two-chunk blob with zero timeout walks the unsent path, the
    // zero-elapsed refusal, resend and its wrap, the full-map rescan and
    // completion; last a 2047 total that acts as 1024, with time extremes.
    // kind, reg, data, req, index, flag, now, fixed, result
    dir_row_t opening_rows [26] = '{
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_NEXT, 10'd0, 1'b0, 32'd0, 1'b1, OUT_IDLE},
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_SENT, 10'd1023, 1'b0, 32'hFFFF_FFFF, 1'b1,
          OUT_REJECT},
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_ACK, 10'd0, 1'b0, 32'd0, 1'b1, OUT_REJECT},
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_NAME, 10'd0, 1'b1, 32'd0, 1'b1, OUT_DONE},
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_NAME, 10'd0, 1'b0, 32'd0, 1'b1, OUT_IDLE},
        '{ROW_REG, CFG_TOTAL, 16'd2, REQ_NEXT, 10'd0, 1'b0, 32'd0, 1'b0, OUT_IDLE},
        '{ROW_REG, CFG_TIMEOUT, 16'd0, REQ_NEXT, 10'd0, 1'b0, 32'd0, 1'b0, OUT_IDLE},
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_NEXT, 10'd0, 1'b0, 32'd100, 1'b0, OUT_IDLE},
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_SENT, 10'd0, 1'b0, 32'd100, 1'b0, OUT_IDLE},
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_NEXT, 10'd0, 1'b0, 32'd100, 1'b0, OUT_IDLE},
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_SENT, 10'd1, 1'b0, 32'd101, 1'b0, OUT_IDLE},
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_NEXT, 10'd0, 1'b0, 32'd101, 1'b0, OUT_IDLE},
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_NEXT, 10'd0, 1'b0, 32'd102, 1'b0, OUT_IDLE},
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_NEXT, 10'd0, 1'b0, 32'd102, 1'b0, OUT_IDLE},
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_SENT, 10'd2, 1'b0, 32'd200, 1'b1, OUT_REJECT},
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_ACK, 10'd0, 1'b0, 32'd200, 1'b0, OUT_IDLE},
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_NEXT, 10'd0, 1'b0, 32'd300, 1'b0, OUT_IDLE},
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_ACK, 10'd1, 1'b0, 32'd300, 1'b0, OUT_IDLE},
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_ACK, 10'd1, 1'b0, 32'd300, 1'b0, OUT_IDLE},
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_NEXT, 10'd0, 1'b0, 32'd300, 1'b1, OUT_IDLE},
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_NAME, 10'd0, 1'b1, 32'd300, 1'b1, OUT_DONE},
        '{ROW_REG, CFG_TOTAL, 16'hFFFF, REQ_NEXT, 10'd0, 1'b0, 32'd0, 1'b0, OUT_IDLE},
        '{ROW_REG, CFG_TIMEOUT, 16'hFFFF, REQ_NEXT, 10'd0, 1'b0, 32'd0, 1'b0, OUT_IDLE},
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_SENT, 10'd1023, 1'b0, 32'hFFFF_FFFF, 1'b0,
          OUT_IDLE},
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_NEXT, 10'd0, 1'b0, 32'd0, 1'b0, OUT_IDLE},
        '{ROW_ITEM, CFG_TOTAL, 16'd0, REQ_ACK, 10'd1023, 1'b0, 32'd0, 1'b0, OUT_IDLE}
    };

    // Random phases: mostly small blobs so the rescans and resend wraps come
    // around often; a few large ones. 16'hF825 checks masking to 37.
    phase_t run_phases [12] = '{
        '{16'd7,     16'd0,     90, 1'b1},
        '{16'd10,    16'd3,     80, 1'b0},
        '{16'd11,    16'd20,    80, 1'b1},
        '{16'd1,     16'd10,    40, 1'b1},
        '{16'hF825,  16'd5,     80, 1'b1},
        '{16'd0,     16'd10,    25, 1'b0},
        '{16'd24,    16'hFFFF,  60, 1'b1},
        '{16'd2,     16'd1,     60, 1'b1},
        '{16'd1024,  16'd0,     30, 1'b0},
        '{16'd200,   16'd7,     40, 1'b1},
        '{16'd5,     16'h8000,  60, 1'b1},
        '{16'd64,    16'd2,     80, 1'b1}
    };

    // Scheduler state as the testbench expects it
    logic [MAX_CHUNKS-1:0] sent_map;
    logic [MAX_CHUNKS-1:0] ack_map;
    logic [TOTAL_W-1:0]    sent_cnt;
    logic [TOTAL_W-1:0]    ack_cnt;
    logic [TOTAL_W-1:0]    unsent_ptr;
    logic [TOTAL_W-1:0]    resend_ptr;
    logic [TIME_W-1:0]     last_send;
    logic                  name_acked;
    logic [TOTAL_W-1:0]    total_reg;
    logic [TIMEOUT_W-1:0]  timeout_reg;

    sched_out_t  due_outcomes [$];
    sched_out_t  head_outcome;
    int          fault_count;

    // Stimulus shaping: a chunk just offered is usually reported sent next
    logic [IDX_W-1:0]  last_offer;
    bit                offer_pending;
    logic [TIME_W-1:0] now_cursor;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned live_total();
        if (total_reg > MAX_CHUNKS)
            return MAX_CHUNKS;
        return total_reg;
    endfunction

    function automatic int unsigned inflight_cap(input int unsigned t);
        if (t == 0)
            return 0;
        if (t <= LIMIT_DIV)
            return 1;
        return t / LIMIT_DIV;
    endfunction

    // first clear entry below t, else t-1
    function automatic logic [TOTAL_W-1:0] first_clear(input logic [MAX_CHUNKS-1:0] map,
                                                       input int unsigned t);
        int i;
        for (i = 0; i < t; i++)
        begin
            if (!map[i])
                return TOTAL_W'(i);
        end
        return TOTAL_W'(t - 1);
    endfunction

    function automatic void clear_blob();
        sent_map   = '0;
        ack_map    = '0;
        sent_cnt   = '0;
        ack_cnt    = '0;
        unsent_ptr = '0;
        resend_ptr = '0;
        last_send  = '0;
        name_acked = 1'b0;
    endfunction

    // Applies one accepted request to the expected state, returns its result
    task automatic advance_scheduler(input req_item_t it, output sched_out_t res);
        int unsigned t;
        int          inflight;
        logic [TIME_W-1:0] elapsed;
        t   = live_total();
        res = OUT_IDLE;
        case (it.req)
            REQ_NEXT:
            begin
                if (ack_cnt < t)
                begin
                    inflight = int'(sent_cnt) - int'(ack_cnt);
                    if (inflight <= int'(inflight_cap(t)))
                    begin
                        if (unsent_ptr >= t)
                            unsent_ptr = first_clear(sent_map, t);
                        res.chunk_valid = 1'b1;
                        res.chunk_out   = unsent_ptr[IDX_W-1:0];
                        unsent_ptr      = unsent_ptr + 1'b1;
                    end
                    else
                    begin
                        // signed 32-bit distance past the timeout, must be > 0
                        elapsed = it.now - TIME_W'(timeout_reg) - last_send;
                        if (elapsed != '0 && !elapsed[TIME_W-1])
                        begin
                            resend_ptr = resend_ptr + 1'b1;
                            if (resend_ptr >= t)
                                resend_ptr = first_clear(ack_map, t);
                            res.chunk_valid = 1'b1;
                            res.chunk_out   = resend_ptr[IDX_W-1:0];
                            res.is_resend   = 1'b1;
                        end
                    end
                end
            end
            REQ_SENT, REQ_ACK:
            begin
                if (it.idx >= t)
                    res.status = 1'b1;
                else if (it.req == REQ_SENT)
                begin
                    if (!sent_map[it.idx])
                    begin
                        sent_map[it.idx] = 1'b1;
                        sent_cnt         = sent_cnt + 1'b1;
                    end
                    last_send = it.now;
                end
                else if (!ack_map[it.idx])
                begin
                    ack_map[it.idx] = 1'b1;
                    ack_cnt         = ack_cnt + 1'b1;
                end
            end
            default:
                name_acked = it.flag;
        endcase
        res.done_res = (ack_cnt >= t) && name_acked;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fault_count++;
        end
    endtask

    // Register write, only once every outstanding result is back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] val);
        @(negedge clk);
        start <= 1'b0;
        while (due_outcomes.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_index <= CFG_IDX_W'($urandom);
        cfg_data  <= CFG_W'($urandom);
        if (sel == CFG_TOTAL)
        begin
            total_reg = val[TOTAL_W-1:0];
            clear_blob();
        end
        else
            timeout_reg = val[TIMEOUT_W-1:0];
        offer_pending = 1'b0;
    endtask

    // Holds one request until the transfer, then queues its result
    task automatic issue_request(input req_item_t it, input bit fixed, input sched_out_t want);
        sched_out_t predicted;
        @(negedge clk);
        start       <= 1'b1;
        req_type    <= it.req;
        chunk_index <= it.idx;
        name_flag   <= it.flag;
        now_ms      <= it.now;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        advance_scheduler(it, predicted);
        due_outcomes.push_back(fixed ? want : predicted);
        if (predicted.chunk_valid)
        begin
            last_offer    = predicted.chunk_out;
            offer_pending = 1'b1;
        end
    endtask

    // Sender idle: start low, junk on the request fields
    task automatic idle_gap(input int unsigned n);
        repeat (n)
        begin
            @(negedge clk);
            start       <= 1'b0;
            req_type    <= REQ_W'($urandom);
            chunk_index <= IDX_W'($urandom);
            name_flag   <= 1'($urandom);
            now_ms      <= $urandom;
        end
    endtask

    function automatic logic [IDX_W-1:0] pick_index(input int unsigned t);
        if (t == 0)
            return IDX_W'($urandom);
        return IDX_W'($urandom_range(0, t - 1));
    endfunction

    // Random request: mostly offer -> sent -> ack traffic over a slowly
    // moving clock, with out-of-range reports and clock jumps mixed in
    task automatic make_request(output req_item_t it);
        int unsigned t;
        int unsigned roll;
        t    = live_total();
        roll = $urandom_range(0, 99);
        if (roll < 70)
            now_cursor += $urandom_range(0, 15);
        else if (roll < 90)
            now_cursor += $urandom_range(0, 300);
        else if (roll < 97)
            now_cursor += $urandom_range(0, 70000);
        else
            now_cursor = $urandom;   // jump anywhere, backward too
        it.now  = now_cursor;
        it.idx  = IDX_W'($urandom);
        it.flag = 1'($urandom);
        if (offer_pending && $urandom_range(0, 9) < 7)
        begin
            it.req        = REQ_SENT;
            it.idx        = last_offer;
            offer_pending = 1'b0;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
                it.req = REQ_NEXT;
            else if (roll < 58)
            begin
                it.req = REQ_SENT;
                it.idx = pick_index(t);
            end
            else if (roll < 86)
            begin
                it.req = REQ_ACK;
                it.idx = pick_index(t);
                if (t != 0 && !sent_map[it.idx] && $urandom_range(0, 1) != 0)
                    it.idx = pick_index(t);
            end
            else if (roll < 92)
            begin
                it.req  = REQ_NAME;
                it.flag = ($urandom_range(0, 3) != 0);
            end
            else
            begin
                it.req = ($urandom_range(0, 1) != 0) ? REQ_SENT : REQ_ACK;
                if (t < MAX_CHUNKS)
                    it.idx = ($urandom_range(0, 1) != 0) ? IDX_W'(t)
                                                         : IDX_W'($urandom_range(t, 1023));
            end
        end
    endtask

    // Result checker: results cannot be held off, take each one as it shows
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (due_outcomes.size() == 0)
            begin
                $error("result with nothing outstanding: chunk_out %0d", chunk_out);
                fault_count++;
            end
            else
            begin
                head_outcome = due_outcomes.pop_front();
                check_field("chunk_valid", head_outcome.chunk_valid, chunk_valid);
                check_field("chunk_out", head_outcome.chunk_out, chunk_out);
                check_field("is_resend", head_outcome.is_resend, is_resend);
                check_field("done_res", head_outcome.done_res, done_res);
                check_field("status", head_outcome.status, status);
            end
        end
    end

    // Watchdog on cycles with neither a request nor a result transfer
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || result_valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : stimulus
        req_item_t   it;
        int          r;
        int          p;
        int          k;
        int unsigned burst_left;

        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        start       = 1'b0;
        req_type    = REQ_NEXT;
        chunk_index = '0;
        name_flag   = 1'b0;
        now_ms      = '0;
        rst_n       = 1'b0;
        fault_count = 0;
        offer_pending = 1'b0;
        last_offer  = '0;
        now_cursor  = '0;
        total_reg   = '0;
        timeout_reg = TIMEOUT_RESET;
        clear_blob();

        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < 26; r++)
        begin
            if (opening_rows[r].kind == ROW_REG)
                write_reg(opening_rows[r].sel, opening_rows[r].val);
            else
            begin
                it.req  = opening_rows[r].req;
                it.idx  = opening_rows[r].idx;
                it.flag = opening_rows[r].flag;
                it.now  = opening_rows[r].now;
                issue_request(it, opening_rows[r].fixed, opening_rows[r].want);
                idle_gap($urandom_range(0, 2));
            end
        end

        for (p = 0; p < 12; p++)
        begin
            write_reg(CFG_TOTAL, run_phases[p].total_val);
            write_reg(CFG_TIMEOUT, run_phases[p].timeout_val);
            now_cursor = $urandom;
            burst_left = $urandom_range(1, 12);
            for (k = 0; k < run_phases[p].count; k++)
            begin
                make_request(it);
                issue_request(it, 1'b0, OUT_IDLE);
                // bursts of back-to-back transfers separated by random gaps
                if (run_phases[p].bursty)
                begin
                    if (burst_left == 0)
                    begin
                        idle_gap($urandom_range(1, 9));
                        burst_left = $urandom_range(1, 12);
                    end
                    else
                        burst_left--;
                end
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (due_outcomes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);

        if (fault_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
